// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define BSR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BSR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define BSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/bsr_pkg.sv =====
// Shared types and constants for the byte stack unit.
package bsr_pkg;

  localparam int STACK_DEPTH_DFLT = 128;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_POP     = 2'd1,
    ACT_REVERSE = 2'd2,
    ACT_CHECK   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] popped_byte;
    status_t    status;
    logic       is_palindrome;
    logic [7:0] fill_count;
  } res_t;

endpackage

// ===== hw/rtl/bsr_mem.sv =====
// Stack storage: one write port, one read port, registered read data.
module bsr_mem #(
  parameter int DEPTH = bsr_pkg::STACK_DEPTH_DFLT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bsr_seq.sv =====
// Sequencer: decodes each word, walks the memory for reverse and check.
`include "assert_macros.svh"

module bsr_seq #(
  parameter int DEPTH = bsr_pkg::STACK_DEPTH_DFLT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_action,
  input  logic [7:0]    in_push_byte,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata,
  output logic          res_valid,
  input  logic          res_ready,
  output bsr_pkg::res_t res
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD_LO = 8'b0000_0010,
    S_RD_HI = 8'b0000_0100,
    S_CMP   = 8'b0000_1000,
    S_WR_LO = 8'b0001_0000,
    S_WR_HI = 8'b0010_0000,
    S_POP   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   lo_r, lo_nxt;
  logic [AW-1:0]   hi_r, hi_nxt;
  logic [7:0]      lo_byte_r, lo_byte_nxt;
  logic            chk_r, chk_nxt;
  bsr_pkg::res_t   res_r, res_nxt;
  bsr_pkg::res_t   res_base;
  bsr_pkg::act_t   act;
  logic            full, empty, more;

  assign act   = bsr_pkg::act_t'(in_action);
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  // another pair remains after the current one
  assign more  = ((AW+1)'(lo_r) + (AW+1)'(2)) < (AW+1)'(hi_r);

  assign res_base = '{popped_byte: 8'd0, status: bsr_pkg::ST_DONE,
                      is_palindrome: 1'b0, fill_count: 8'd0};

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    lo_byte_nxt = lo_byte_r;
    chk_nxt     = chk_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = lo_r;
    mem_wdata   = mem_rdata;
    mem_raddr   = lo_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = res_base;
          state_nxt = S_OUT;
          case (act)
            bsr_pkg::ACT_PUSH: begin
              if (full) begin
                res_nxt.status = bsr_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_push_byte;
                count_nxt = count_r + 1'b1;
              end
            end
            bsr_pkg::ACT_POP: begin
              if (empty) begin
                res_nxt.status = bsr_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                mem_raddr = AW'(count_r - 1'b1);
                state_nxt = S_POP;
              end
            end
            bsr_pkg::ACT_REVERSE, bsr_pkg::ACT_CHECK: begin
              if (empty) begin
                res_nxt.status = bsr_pkg::ST_EMPTY;
              end else if (count_r == CW'(1)) begin
                res_nxt.is_palindrome = (act == bsr_pkg::ACT_CHECK);
              end else begin
                lo_nxt    = '0;
                hi_nxt    = AW'(count_r - 1'b1);
                chk_nxt   = (act == bsr_pkg::ACT_CHECK);
                state_nxt = S_RD_LO;
              end
            end
            default: begin
              res_nxt.status = bsr_pkg::ST_DONE;
            end
          endcase
        end
      end
      S_RD_LO: begin
        mem_raddr = lo_r;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        mem_raddr   = hi_r;
        lo_byte_nxt = mem_rdata;
        state_nxt   = chk_r ? S_CMP : S_WR_LO;
      end
      S_CMP: begin
        // read data now holds the upper entry
        if (mem_rdata != lo_byte_r) begin
          res_nxt   = res_base;
          state_nxt = S_OUT;
        end else if (more) begin
          lo_nxt    = lo_r + 1'b1;
          hi_nxt    = hi_r - 1'b1;
          state_nxt = S_RD_LO;
        end else begin
          res_nxt               = res_base;
          res_nxt.is_palindrome = 1'b1;
          state_nxt             = S_OUT;
        end
      end
      S_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = mem_rdata;
        state_nxt = S_WR_HI;
      end
      S_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = lo_byte_r;
        if (more) begin
          lo_nxt    = lo_r + 1'b1;
          hi_nxt    = hi_r - 1'b1;
          state_nxt = S_RD_LO;
        end else begin
          res_nxt   = res_base;
          state_nxt = S_OUT;
        end
      end
      S_POP: begin
        res_nxt             = res_base;
        res_nxt.popped_byte = mem_rdata;
        state_nxt           = S_OUT;
      end
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if ((state_nxt == S_OUT) && (state_r != S_OUT)) begin
      res_nxt.fill_count = 8'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    lo_byte_r <= lo_byte_nxt;
    chk_r     <= chk_nxt;
    res_r     <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res       = res_r;

  `BSR_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "count over depth")
  `BSR_ASSERT_SAME(a_walk_order, clk, rst_n, (state_r == S_RD_LO) || (state_r == S_RD_HI) || (state_r == S_CMP) || (state_r == S_WR_LO) || (state_r == S_WR_HI), lo_r < hi_r, "walk pointers crossed")
  `BSR_ASSERT_NEXT(a_push_count, clk, rst_n, in_valid && in_ready && (act == bsr_pkg::ACT_PUSH) && !full, count_r == $past(count_r) + 1'b1, "push lost")
  `BSR_ASSERT_SAME(a_no_rd_wr_clash, clk, rst_n, mem_we && ((state_r == S_RD_LO) || (state_r == S_RD_HI)), 1'b0, "write during read phase")

endmodule

// ===== hw/rtl/byte_stack_reverse_palindrome_unit.sv =====
// Byte stack with in-place reverse and palindrome check: top level.
//
// A bounded LIFO of STACK_DEPTH bytes held in a single-port-write,
// single-port-read synchronous RAM. Each input word carries an action
// (push, pop, reverse, check) and a byte for push; each produces exactly
// one result word with the popped byte, a status (done, full, empty), the
// palindrome flag and the fill count after the action (modulo 256).
// The sequencer paces the one RAM read port: push and any refused action go
// from idle to the result register, pop through the pop state, check through
// read-low, read-high and compare per pair, and reverse through read-low,
// read-high, write-low and write-high per pair, then hand over. Check
// stops at the first mismatch. One word is worked on at a time; in_ready is
// high whenever the sequencer is idle, even while the output register still
// holds an untaken result. A read and a write of the same entry share a cycle
// only where the read data is thrown away (a push, the lower write of a
// swap), so no forwarding is needed. The RAM needs no clearing
// after reset: only entries below the fill count are ever read.
module byte_stack_reverse_palindrome_unit #(
  parameter int STACK_DEPTH = bsr_pkg::STACK_DEPTH_DFLT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_push_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_popped_byte,
  output logic [1:0] out_status,
  output logic       out_is_palindrome,
  output logic [7:0] out_fill_count
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic          res_valid;
  logic          res_ready;
  bsr_pkg::res_t res;

  // output register
  logic          out_valid_r, out_valid_nxt;
  bsr_pkg::res_t out_res_r, out_res_nxt;

  bsr_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bsr_seq #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_push_byte (in_push_byte),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // a new result may load when the register is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_popped_byte   = out_res_r.popped_byte;
  assign out_status        = out_res_r.status;
  assign out_is_palindrome = out_res_r.is_palindrome;
  assign out_fill_count    = out_res_r.fill_count;

endmodule

// ===== test/stack_result_checker.sv =====
// Checker for the byte stack unit: predicts each result word and compares it.
module stack_result_checker #(
  parameter int DEPTH = bsr_pkg::STACK_DEPTH_DFLT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_push_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_popped_byte,
  input  logic [1:0] out_status,
  input  logic       out_is_palindrome,
  input  logic [7:0] out_fill_count,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output int         full_seen,
  output int         empty_seen,
  output int         pal_seen
);
  import bsr_pkg::*;

  // int counters start at zero
  logic [7:0] stack_img [DEPTH];
  int         held;
  int         fails;
  int         n_checked, n_full, n_empty, n_pal;
  res_t       expected_results [$];

  // Applies one action to the local stack image and returns the word it yields.
  function automatic res_t predict_stack_step(act_t act, logic [7:0] b);
    res_t       r;
    int         lo, hi;
    logic [7:0] t;
    r = '0;
    r.status = ST_DONE;
    case (act)
      ACT_PUSH: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_img[held] = b;
          held++;
        end
      end
      ACT_POP: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          held--;
          r.popped_byte = stack_img[held];
        end
      end
      ACT_REVERSE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lo = 0;
          hi = held - 1;
          while (lo < hi) begin
            t = stack_img[lo];
            stack_img[lo] = stack_img[hi];
            stack_img[hi] = t;
            lo++;
            hi--;
          end
        end
      end
      default: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.is_palindrome = 1'b1;
          lo = 0;
          hi = held - 1;
          while (lo < hi) begin
            if (stack_img[lo] != stack_img[hi]) r.is_palindrome = 1'b0;
            lo++;
            hi--;
          end
        end
      end
    endcase
    r.fill_count = held[7:0];
    return r;
  endfunction

  task automatic note_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      held = 0;
      expected_results.delete();
    end else begin
      // a result never leaves in the cycle its word is taken, so order is safe
      if (in_valid && in_ready)
        expected_results.push_back(predict_stack_step(act_t'(in_action), in_push_byte));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected: popped %0h status %0d pal %0d fill %0d",
                   $time, out_popped_byte, out_status, out_is_palindrome, out_fill_count);
          fails++;
        end else begin
          want = expected_results.pop_front();
          note_field("popped_byte", want.popped_byte, out_popped_byte);
          note_field("status", want.status, out_status);
          note_field("is_palindrome", want.is_palindrome, out_is_palindrome);
          note_field("fill_count", want.fill_count, out_fill_count);
          n_checked++;
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_EMPTY) n_empty++;
          if (want.is_palindrome) n_pal++;
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_results.size();
    checked    <= n_checked;
    full_seen  <= n_full;
    empty_seen <= n_empty;
    pal_seen   <= n_pal;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the byte stack testbench: clock, reset, stimulus and verdict.
module testbench;
  import bsr_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DFLT;
  localparam int WORDS_WANTED = 2000;
  // worst single word is a reverse over a full stack
  localparam int TAIL_CYCLES  = 4 * DEPTH + 50;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = 2'b00;
  logic [7:0] in_push_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_popped_byte;
  logic [1:0] out_status;
  logic       out_is_palindrome;
  logic [7:0] out_fill_count;

  int fail_count, pending, checked, full_seen, empty_seen, pal_seen;

  // idling odds in percent, changed per phase
  int send_idle_pct = 10;
  int recv_idle_pct = 83;

  int sent = 0;
  // rough fill level, kept only to shape the stimulus
  int depth_est = 0;
  logic [7:0] mirror [64];

  always #6 clk = ~clk;

  byte_stack_reverse_palindrome_unit #(.STACK_DEPTH(DEPTH)) uut (.*);

  stack_result_checker #(.DEPTH(DEPTH)) scoreboard (.*);

  // Receiver: ready drawn fresh every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one word, with random idle cycles ahead of it, and waits until taken.
  task automatic send_word(act_t act, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_push_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (act == ACT_PUSH && depth_est < DEPTH) depth_est++;
    if (act == ACT_POP && depth_est > 0) depth_est--;
  endtask

  // Holds the sender off until every expected result word has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic empty_stack();
    while (depth_est > 0) send_word(ACT_POP, 8'($urandom));
  endtask

  initial begin : stimulus
    int phase, pick, half, odd, spoil, spoil_at;
    logic [7:0] b;
    phase = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: refusals on an empty stack, a single entry, the byte extremes,
    // an odd-length palindrome, a mismatch, then pop back past empty.
    send_word(ACT_POP, 8'hFF);
    send_word(ACT_REVERSE, 8'hFF);
    send_word(ACT_CHECK, 8'h00);
    send_word(ACT_PUSH, 8'h00);
    send_word(ACT_CHECK, 8'h00);   // single entry counts as symmetric
    send_word(ACT_REVERSE, 8'h00); // single entry stays put
    send_word(ACT_POP, 8'h00);
    send_word(ACT_PUSH, 8'hFF);
    send_word(ACT_PUSH, 8'h5A);
    send_word(ACT_PUSH, 8'hFF);
    send_word(ACT_CHECK, 8'hAA);
    send_word(ACT_REVERSE, 8'h55);
    send_word(ACT_PUSH, 8'hA5);
    send_word(ACT_CHECK, 8'h00);
    send_word(ACT_REVERSE, 8'h00);
    repeat (5) send_word(ACT_POP, 8'h00);

    // Random: palindrome runs built on an empty stack, fill bursts
    // that overrun the top, drains that underrun the bottom, and loose noise.
    while (sent < WORDS_WANTED) begin
      if (phase == 0 && sent >= WORDS_WANTED / 3) begin
        wait_for_results();
        send_idle_pct = 83;
        recv_idle_pct = 10;
        phase = 1;
      end else if (phase == 1 && sent >= 2 * WORDS_WANTED / 3) begin
        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase = 2;
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        empty_stack();
        half = ($urandom_range(9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
        odd = (2 * half < DEPTH) ? $urandom_range(1) : 0;
        spoil = ($urandom_range(1) == 0);
        spoil_at = $urandom_range(half - 1);
        for (int i = 0; i < half; i++) begin
          mirror[i] = 8'($urandom);
          send_word(ACT_PUSH, mirror[i]);
        end
        if (odd != 0) send_word(ACT_PUSH, 8'($urandom));
        for (int i = half - 1; i >= 0; i--) begin
          b = mirror[i];
          if (spoil && i == spoil_at) b = b ^ (8'h01 << $urandom_range(7));
          send_word(ACT_PUSH, b);
        end
        send_word(ACT_CHECK, 8'($urandom));
        send_word(ACT_REVERSE, 8'($urandom));
        send_word(ACT_CHECK, 8'($urandom));
        repeat ($urandom_range(0, 3)) send_word(ACT_POP, 8'($urandom));
      end else if (pick < 43) begin
        while (depth_est < DEPTH) send_word(ACT_PUSH, 8'($urandom));
        repeat ($urandom_range(1, 3)) send_word(ACT_PUSH, 8'($urandom));
        send_word(ACT_REVERSE, 8'($urandom));
        send_word(ACT_CHECK, 8'($urandom));
        repeat ($urandom_range(0, DEPTH)) send_word(ACT_POP, 8'($urandom));
      end else if (pick < 48) begin
        empty_stack();
        repeat ($urandom_range(1, 3)) send_word(act_t'($urandom_range(1, 3)), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 20)) begin
          pick = $urandom_range(9);
          if (pick < 4)      send_word(ACT_PUSH, 8'($urandom));
          else if (pick < 6) send_word(ACT_POP, 8'($urandom));
          else if (pick < 8) send_word(ACT_REVERSE, 8'($urandom));
          else               send_word(ACT_CHECK, 8'($urandom));
        end
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words over three idling phases; %0d results checked",
             sent, checked);
    $display("with %0d full refusals, %0d empty refusals and %0d palindromes found",
             full_seen, empty_seen, pal_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run.
  initial begin
    #60000000;
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bsr_pkg.sv
hw/rtl/bsr_mem.sv
hw/rtl/bsr_seq.sv
hw/rtl/byte_stack_reverse_palindrome_unit.sv
test/stack_result_checker.sv
test/testbench.sv
